[sv/btpc_pkg.sv]
// Shared constants, types and helper functions of the binary trie prefix counter.
package btpc_pkg;

    localparam int NODES   = 4096;
    localparam int MAX_LEN = 32;
    localparam int NODE_W  = $clog2(NODES);
    localparam int LEN_W   = 6;
    localparam int BITS_W  = 32;
    localparam int CNT_W   = 32;
    localparam int LEN_LIM = (MAX_LEN < BITS_W) ? MAX_LEN : BITS_W;
    localparam int CMP_W   = (NODE_W > LEN_W) ? NODE_W : LEN_W;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [NODE_W-1:0] child1;
        logic [NODE_W-1:0] child0;
        logic [CNT_W-1:0]  pass_cnt;
        logic [CNT_W-1:0]  end_cnt;
    } node_t;

    typedef struct packed {
        logic              re;
        logic [NODE_W-1:0] raddr;
        logic              we;
        logic [NODE_W-1:0] waddr;
        node_t             wdata;
    } ram_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_TAIL0,
        ST_TAIL1,
        ST_UPD,
        ST_NEW,
        ST_DONE
    } state_t;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] a);
        return (a == {CNT_W{1'b1}}) ? a : a + CNT_W'(1);
    endfunction

endpackage

[sv/btpc_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read.
module btpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/btpc_ctrl.sv]
// Sequencer that walks, checks and updates the trie in the node memory.
module btpc_ctrl
    import btpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              kind,
    input  logic [LEN_W-1:0]  length,
    input  logic [BITS_W-1:0] bits,
    output logic              res_valid,
    input  logic              res_ready,
    output logic [CNT_W-1:0]  res_count,
    output logic              res_status,
    output ram_req_t          ram_req,
    input  node_t             ram_rdata
);

    state_t             state_reg,  state_next;
    logic               kind_reg,   kind_next;
    logic [LEN_W-1:0]   len_reg,    len_next;
    logic [BITS_W-1:0]  bits_reg,   bits_next;
    logic [LEN_W-1:0]   depth_reg,  depth_next;
    logic [NODE_W-1:0]  node_reg,   node_next;
    logic [NODE_W-1:0]  c1_reg,     c1_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic               status_reg, status_next;
    logic [NODE_W-1:0]  nf_reg,     nf_next;
    logic               root_valid_reg, root_valid_next;

    node_t              cur;
    node_t              upd;
    logic               bit_now;
    logic [NODE_W-1:0]  child;
    logic [NODE_W-1:0]  new_id;
    logic               at_end;
    logic [CMP_W-1:0]   need;
    logic [CMP_W-1:0]   avail;
    logic [LEN_W-1:0]   len_clip;

    assign len_clip = (length > LEN_W'(LEN_LIM)) ? LEN_W'(LEN_LIM) : length;
    assign cur      = ((node_reg == '0) && !root_valid_reg) ? '0 : ram_rdata;
    assign bit_now  = bits_reg[depth_reg[$clog2(BITS_W)-1:0]];
    assign child    = bit_now ? cur.child1 : cur.child0;
    assign at_end   = (depth_reg == len_reg);
    assign new_id   = nf_reg + NODE_W'(1);
    assign need     = CMP_W'(len_reg - depth_reg);
    assign avail    = CMP_W'(NODE_W'(NODES - 1) - nf_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            nf_reg         <= '0;
            root_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            nf_reg         <= nf_next;
            root_valid_reg <= root_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        len_reg    <= len_next;
        bits_reg   <= bits_next;
        depth_reg  <= depth_next;
        node_reg   <= node_next;
        c1_reg     <= c1_next;
        count_reg  <= count_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        len_next        = len_reg;
        bits_next       = bits_reg;
        depth_next      = depth_reg;
        node_next       = node_reg;
        c1_next         = c1_reg;
        count_next      = count_reg;
        status_next     = status_reg;
        nf_next         = nf_reg;
        root_valid_next = root_valid_reg;
        ram_req         = '0;
        upd             = cur;
        in_ready        = 1'b0;
        res_valid       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    kind_next     = kind;
                    len_next      = len_clip;
                    bits_next     = bits;
                    depth_next    = '0;
                    node_next     = '0;
                    count_next    = '0;
                    status_next   = STATUS_OK;
                    ram_req.re    = 1'b1;
                    ram_req.raddr = '0;
                    state_next    = ST_WALK;
                end
            end

            ST_WALK:
            begin
                if (kind_reg == KIND_QUERY)
                begin
                    count_next = sat_add(count_reg, cur.end_cnt);
                    if (at_end)
                    begin
                        c1_next = cur.child1;
                        if (cur.child0 != '0)
                        begin
                            ram_req.re    = 1'b1;
                            ram_req.raddr = cur.child0;
                            state_next    = ST_TAIL0;
                        end
                        else if (cur.child1 != '0)
                        begin
                            ram_req.re    = 1'b1;
                            ram_req.raddr = cur.child1;
                            state_next    = ST_TAIL1;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    else if (child == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = child;
                        node_next     = child;
                        depth_next    = depth_reg + LEN_W'(1);
                    end
                end
                else
                begin
                    if (at_end || (child == '0 && need <= avail))
                    begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = '0;
                        node_next     = '0;
                        depth_next    = '0;
                        state_next    = ST_UPD;
                    end
                    else if (child == '0)
                    begin
                        status_next = STATUS_FULL;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = child;
                        node_next     = child;
                        depth_next    = depth_reg + LEN_W'(1);
                    end
                end
            end

            ST_TAIL0:
            begin
                count_next = sat_add(count_reg, ram_rdata.pass_cnt);
                if (c1_reg != '0)
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = c1_reg;
                    state_next    = ST_TAIL1;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_TAIL1:
            begin
                count_next = sat_add(count_reg, ram_rdata.pass_cnt);
                state_next = ST_DONE;
            end

            ST_UPD:
            begin
                if (depth_reg != '0)
                begin
                    upd.pass_cnt = sat_inc(cur.pass_cnt);
                end
                ram_req.we    = 1'b1;
                ram_req.waddr = node_reg;
                if (node_reg == '0)
                begin
                    root_valid_next = 1'b1;
                end
                if (at_end)
                begin
                    upd.end_cnt = sat_inc(cur.end_cnt);
                    state_next  = ST_DONE;
                end
                else if (child == '0)
                begin
                    if (bit_now)
                    begin
                        upd.child1 = new_id;
                    end
                    else
                    begin
                        upd.child0 = new_id;
                    end
                    nf_next    = new_id;
                    node_next  = new_id;
                    depth_next = depth_reg + LEN_W'(1);
                    state_next = ST_NEW;
                end
                else
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = child;
                    node_next     = child;
                    depth_next    = depth_reg + LEN_W'(1);
                end
                ram_req.wdata = upd;
            end

            ST_NEW:
            begin
                upd          = '0;
                upd.pass_cnt = CNT_W'(1);
                ram_req.we    = 1'b1;
                ram_req.waddr = node_reg;
                if (at_end)
                begin
                    upd.end_cnt = CNT_W'(1);
                    state_next  = ST_DONE;
                end
                else
                begin
                    if (bit_now)
                    begin
                        upd.child1 = new_id;
                    end
                    else
                    begin
                        upd.child0 = new_id;
                    end
                    nf_next    = new_id;
                    node_next  = new_id;
                    depth_next = depth_reg + LEN_W'(1);
                end
                ram_req.wdata = upd;
            end

            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res_count  = count_reg;
    assign res_status = status_reg;

endmodule

[sv/binary_trie_prefix_counter.sv]
// Top level of the binary trie prefix counter: sequencer, node memory and result register.
//
// An item on the input channel (in_valid/in_ready) carries kind, length and bits.
// An insert (kind 0) adds the string to the trie; a query (kind 1) returns in count
// the number of stored strings that are a prefix of the string or extend it.
// Every item gives exactly one result on the output channel (out_valid/out_ready).
// Items are handled one at a time; the trie walk reads one level per cycle
// from the node memory, whose registered read sets the rate.
// An insert walks the string twice, the free-node check and then the update;
// an insert that would overflow the node pool stops after the first walk and
// returns status 1.
// The next item is accepted at the earliest in the cycle after the result
// moves to the output register.
// Reset is immediate: the node memory needs no clearing pass, since nodes are
// handed out in order and each new node is written in full when allocated.
// A finished result waits in the output register while the next item is
// accepted; a stalled receiver holds the block once a second result is ready.
module binary_trie_prefix_counter
    import btpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              kind,
    input  logic [LEN_W-1:0]  length,
    input  logic [BITS_W-1:0] bits,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CNT_W-1:0]  count,
    output logic              status
);

    ram_req_t           ram_req;
    node_t              ram_rdata;
    logic               res_valid;
    logic               res_ready;
    logic [CNT_W-1:0]   res_count;
    logic               res_status;

    logic               out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]   count_reg,     count_next;
    logic               status_reg,    status_next;

    btpc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .length     (length),
        .bits       (bits),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_count  (res_count),
        .res_status (res_status),
        .ram_req    (ram_req),
        .ram_rdata  (ram_rdata)
    );

    btpc_ram #(
        .WIDTH ($bits(node_t)),
        .DEPTH (NODES)
    ) u_node_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            count_next     = res_count;
            status_next    = res_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg  <= count_next;
        status_reg <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign count     = count_reg;
    assign status    = status_reg;

endmodule

[tb/testbench.sv]
// Self-checking testbench of the binary trie prefix counter with its own trie predictor.
`timescale 1ns / 100ps

module testbench;
    import btpc_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 100;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             status;
    } answer_t;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [BITS_W-1:0] bits;
    } word_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic              kind      = KIND_INSERT;
    logic [LEN_W-1:0]  length    = '0;
    logic [BITS_W-1:0] bits      = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [CNT_W-1:0]  count;
    logic              status;

    logic [NODE_W-1:0] trie_child [NODES][2];
    logic [CNT_W-1:0]  trie_pass [NODES];
    logic [CNT_W-1:0]  trie_end [NODES];
    int unsigned       trie_last_node = 0;

    answer_t pending_answers [$];
    word_t   inserted_words [$];
    int      mismatches   = 0;
    int      idle_cycles  = 0;
    int      stall_left   = 0;
    bit      tx_gaps_on   = 1'b1;
    bit      rx_stalls_on = 1'b1;

    binary_trie_prefix_counter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .length    (length),
        .bits      (bits),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .count     (count),
        .status    (status)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [CNT_W-1:0] cnt_plus(input logic [CNT_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[CNT_W])
            return {CNT_W{1'b1}};
        return s[CNT_W-1:0];
    endfunction

    // Applies one item to the trie copy and returns the answer the block must give.
    function automatic answer_t trie_apply(input logic k, input logic [LEN_W-1:0] n,
                                           input logic [BITS_W-1:0] b);
        answer_t     ans;
        int unsigned len;
        int unsigned depth;
        int unsigned node;
        int unsigned nxt;
        bit          broken;
        ans.count  = '0;
        ans.status = STATUS_OK;
        len = n;
        if (len > LEN_LIM)
            len = LEN_LIM;
        node  = 0;
        depth = 0;
        if (k == KIND_INSERT)
        begin
            while (depth < len && trie_child[node][b[depth]] != 0)
            begin
                node = trie_child[node][b[depth]];
                depth++;
            end
            if (len - depth > NODES - 1 - trie_last_node)
            begin
                ans.status = STATUS_FULL;
            end
            else
            begin
                node = 0;
                for (depth = 0; depth < len; depth++)
                begin
                    nxt = trie_child[node][b[depth]];
                    if (nxt == 0)
                    begin
                        trie_last_node++;
                        nxt = trie_last_node;
                        trie_child[node][b[depth]] = NODE_W'(nxt);
                    end
                    node = nxt;
                    trie_pass[node] = cnt_plus(trie_pass[node], CNT_W'(1));
                end
                trie_end[node] = cnt_plus(trie_end[node], CNT_W'(1));
            end
        end
        else
        begin
            broken    = 1'b0;
            ans.count = trie_end[0];
            for (depth = 0; depth < len && !broken; depth++)
            begin
                nxt = trie_child[node][b[depth]];
                if (nxt == 0)
                begin
                    broken = 1'b1;
                end
                else
                begin
                    node      = nxt;
                    ans.count = cnt_plus(ans.count, trie_end[node]);
                end
            end
            if (!broken)
            begin
                if (trie_child[node][0] != 0)
                    ans.count = cnt_plus(ans.count, trie_pass[trie_child[node][0]]);
                if (trie_child[node][1] != 0)
                    ans.count = cnt_plus(ans.count, trie_pass[trie_child[node][1]]);
            end
        end
        return ans;
    endfunction

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (!tx_gaps_on || r < 60)
            return 0;
        if (r < 96)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Most words reuse a stored string, a prefix of it or an extension of it.
    function automatic word_t pick_word(input int unsigned fresh_pct);
        word_t             w;
        int unsigned       sel;
        int unsigned       keep;
        logic [BITS_W-1:0] mask;
        sel = $urandom_range(99);
        if (inserted_words.size() == 0 || sel < fresh_pct)
        begin
            if ($urandom_range(4) != 0)
                w.len = LEN_W'($urandom_range(10));
            else
                w.len = LEN_W'($urandom_range(63));
            w.bits = $urandom;
            return w;
        end
        w   = inserted_words[$urandom_range(inserted_words.size() - 1)];
        sel = $urandom_range(99);
        if (sel < 25)
        begin
            w.len = LEN_W'($urandom_range(w.len));
        end
        else if (sel < 50)
        begin
            keep   = (w.len > LEN_LIM) ? LEN_LIM : w.len;
            mask   = BITS_W'((64'd1 << keep) - 64'd1);
            w.bits = (w.bits & mask) | ($urandom & ~mask);
            w.len  = LEN_W'(keep + $urandom_range(4));
        end
        return w;
    endfunction

    task automatic send_item(input logic k, input logic [LEN_W-1:0] n,
                             input logic [BITS_W-1:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        length   <= n;
        bits     <= b;
        do @(posedge clk); while (!in_ready);
        pending_answers.insert(pending_answers.size(), trie_apply(k, n, b));
        if (k == KIND_INSERT)
            inserted_words.insert(inserted_words.size(), {n, b});
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_answers.size() != 0);
    endtask

    task automatic test_empty_trie();
        send_item(KIND_QUERY, LEN_W'(0), 32'h0000_0000);
        send_item(KIND_QUERY, LEN_W'(32), 32'hFFFF_FFFF);
        send_item(KIND_QUERY, LEN_W'(63), 32'h5555_5555);
    endtask

    task automatic test_edge_strings();
        send_item(KIND_INSERT, LEN_W'(0), 32'h0000_0000);
        send_item(KIND_QUERY, LEN_W'(0), 32'hFFFF_FFFF);
        send_item(KIND_INSERT, LEN_W'(32), 32'hFFFF_FFFF);
        send_item(KIND_INSERT, LEN_W'(63), 32'h0000_0000);
        send_item(KIND_INSERT, LEN_W'(1), 32'h0000_0001);
        send_item(KIND_INSERT, LEN_W'(3), 32'h0000_0005);
        send_item(KIND_QUERY, LEN_W'(0), 32'h0000_0000);
        send_item(KIND_QUERY, LEN_W'(1), 32'h0000_0001);
        send_item(KIND_QUERY, LEN_W'(40), 32'hFFFF_FFFF);
        send_item(KIND_QUERY, LEN_W'(2), 32'h0000_0003);
        send_item(KIND_QUERY, LEN_W'(4), 32'h0000_0005);
        send_item(KIND_QUERY, LEN_W'(32), 32'h0000_0001);
        send_item(KIND_INSERT, LEN_W'(32), 32'hFFFF_FFFF);
        send_item(KIND_QUERY, LEN_W'(32), 32'hFFFF_FFFF);
        send_item(KIND_INSERT, LEN_W'(32), 32'h8000_0000);
        send_item(KIND_QUERY, LEN_W'(31), 32'h0000_0000);
        send_item(KIND_QUERY, LEN_W'(63), 32'h8000_0000);
        send_item(KIND_INSERT, LEN_W'(33), 32'hA5A5_A5A5);
        send_item(KIND_QUERY, LEN_W'(16), 32'h0000_A5A5);
        send_item(KIND_QUERY, LEN_W'(32), 32'h7FFF_FFFF);
    endtask

    task automatic test_random_traffic(input int items);
        int    i;
        word_t w;
        for (i = 0; i < items; i++)
        begin
            if (i % 100 == 0)
            begin
                tx_gaps_on   = (i != 0) && ($urandom_range(3) != 0);
                rx_stalls_on = (i != 0) && ($urandom_range(3) != 0);
            end
            if (i % 150 == 149)
                wait_all_results();
            if ($urandom_range(1) == 1)
            begin
                w = pick_word(5);
                send_item(KIND_QUERY, w.len, w.bits);
            end
            else
            begin
                w = pick_word(30);
                send_item(KIND_INSERT, w.len, w.bits);
            end
        end
    endtask

    task automatic test_pool_full();
        int    i;
        word_t w;
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        i = 0;
        while (trie_last_node < NODES - 48)
        begin
            if (i % 4 == 3)
            begin
                w = pick_word(0);
                send_item(KIND_QUERY, w.len, w.bits);
            end
            else
            begin
                send_item(KIND_INSERT, LEN_W'(32), $urandom);
            end
            i++;
        end
        for (i = 0; i < 70; i++)
        begin
            case ($urandom_range(2))
                0:
                begin
                    w = pick_word(10);
                    send_item(KIND_QUERY, w.len, w.bits);
                end
                1:
                begin
                    w = pick_word(0);
                    send_item(KIND_INSERT, w.len, w.bits);
                end
                default:
                begin
                    send_item(KIND_INSERT, LEN_W'($urandom_range(63, 1)), $urandom);
                end
            endcase
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (rx_stalls_on && $urandom_range(99) < 20)
        begin
            if ($urandom_range(19) == 0)
                stall_left <= $urandom_range(60, 20);
            else
                stall_left <= $urandom_range(2);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("result with no item pending: count %0d, status %0d", count, status);
                mismatches++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (count !== want.count)
                begin
                    $error("count: expected %0d, actual %0d", want.count, count);
                    mismatches++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int n;
        for (n = 0; n < NODES; n++)
        begin
            trie_child[n][0] = '0;
            trie_child[n][1] = '0;
            trie_pass[n]     = '0;
            trie_end[n]      = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_trie();
        test_edge_strings();
        test_random_traffic(620);
        test_pool_full();
        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
